// ----- src/solovay_strassen_primality_defines.svh -----
// Assertion macros for the primality tester.
// Each macro needs clk and rst_n in scope where it is used.
`ifndef SOLOVAY_STRASSEN_PRIMALITY_DEFINES_SVH
`define SOLOVAY_STRASSEN_PRIMALITY_DEFINES_SVH

// Same-cycle implication
`define SSP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SSP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ssp_pkg.sv -----
// ---------------------------------------------------------------------------
// ssp_pkg
// Shared constants, verdict codes and status types of the primality tester.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssp_pkg;

    localparam int NUMBER_BITS_DEF = 32;
    localparam int CAND_W          = 32;
    localparam int ROUND_W         = 6;
    localparam int BASE_W          = 8;
    localparam logic [ROUND_W-1:0] ROUND_RESET = 6'd14;

    typedef logic [2:0] verdict_t;
    localparam verdict_t V_TRIVIAL  = 3'd0;
    localparam verdict_t V_GCD      = 3'd1;
    localparam verdict_t V_EULER    = 3'd2;
    localparam verdict_t V_SMALL    = 3'd3;
    localparam verdict_t V_PROBABLE = 3'd4;

    // Status of the remainder / Jacobi unit
    typedef struct packed {
        logic done;
        logic coprime;
        logic neg;
    } jac_stat_t;

endpackage

`default_nettype wire

// ----- src/ssp_modmul.sv -----
// ---------------------------------------------------------------------------
// ssp_modmul
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssp_modmul #(
    parameter int NB = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NB-1:0] a,
    input  wire logic [NB-1:0] b,
    input  wire logic [NB-1:0] m,
    output logic               done,
    output logic [NB-1:0]      result
);
    localparam int CW = $clog2(NB + 1);

    logic [NB-1:0] a_reg, b_reg, acc_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [NB+1:0] s;
    logic [NB+2:0] d1, d2;
    logic [NB-1:0] acc_next;

    // 2*acc + bit*a, then reduce by m or 2m (s stays below 3m)
    always_comb
    begin
        s  = {1'b0, acc_reg, 1'b0} + {2'b00, (b_reg[NB-1] ? a_reg : {NB{1'b0}})};
        d1 = {1'b0, s} - {3'b000, m};
        d2 = {1'b0, s} - {2'b00, m, 1'b0};
        if (!d2[NB+2])
            acc_next = d2[NB-1:0];
        else if (!d1[NB+2])
            acc_next = d1[NB-1:0];
        else
            acc_next = s[NB-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NB);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[NB-2:0], 1'b0};
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

`default_nettype wire

// ----- src/ssp_jacobi.sv -----
// ---------------------------------------------------------------------------
// ssp_jacobi
// Serial n mod base, then binary Jacobi symbol (base/n) and coprimality.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssp_jacobi #(
    parameter int NB = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [NB-1:0]             n,
    input  wire logic [ssp_pkg::BASE_W-1:0] base,
    output ssp_pkg::jac_stat_t             stat
);
    import ssp_pkg::*;

    localparam int CW = $clog2(NB + 1);

    typedef enum logic [2:0] {
        J_IDLE = 3'b001,
        J_REM  = 3'b010,
        J_LOOP = 3'b100
    } jstate_t;

    jstate_t           state_reg;
    logic [NB-1:0]     n_sh_reg;
    logic [BASE_W-1:0] base_reg, a_reg, m_reg;
    logic [BASE_W:0]   rem_reg, rem_t, rem_next;
    logic [CW-1:0]     cnt_reg;
    logic              flip_reg, done_reg, coprime_reg;

    // One quotient bit of the restoring division
    always_comb
    begin
        rem_t = {rem_reg[BASE_W-1:0], n_sh_reg[NB-1]};
        if (rem_t >= {1'b0, base_reg})
            rem_next = rem_t - {1'b0, base_reg};
        else
            rem_next = rem_t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= J_IDLE;
            done_reg    <= 1'b0;
            coprime_reg <= 1'b0;
            flip_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                J_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= J_REM;
                        cnt_reg   <= CW'(NB);
                        // reciprocity flip of the first swap
                        flip_reg  <= (n[1:0] == 2'b11) && (base[1:0] == 2'b11);
                    end
                end
                J_REM:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1))
                        state_reg <= J_LOOP;
                end
                J_LOOP:
                begin
                    if (a_reg == '0)
                    begin
                        done_reg    <= 1'b1;
                        coprime_reg <= (m_reg == BASE_W'(1));
                        state_reg   <= J_IDLE;
                    end
                    else if (!a_reg[0])
                    begin
                        if (m_reg[2:0] == 3'd3 || m_reg[2:0] == 3'd5)
                            flip_reg <= ~flip_reg;
                    end
                    else if (a_reg < m_reg)
                    begin
                        if (a_reg[1:0] == 2'b11 && m_reg[1:0] == 2'b11)
                            flip_reg <= ~flip_reg;
                    end
                end
                default:
                    state_reg <= J_IDLE;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == J_IDLE && start)
        begin
            n_sh_reg <= n;
            base_reg <= base;
            rem_reg  <= '0;
        end
        else if (state_reg == J_REM)
        begin
            rem_reg  <= rem_next;
            n_sh_reg <= {n_sh_reg[NB-2:0], 1'b0};
            if (cnt_reg == CW'(1))
            begin
                a_reg <= rem_next[BASE_W-1:0];
                m_reg <= base_reg;
            end
        end
        else if (state_reg == J_LOOP && a_reg != '0)
        begin
            if (!a_reg[0])
                a_reg <= {1'b0, a_reg[BASE_W-1:1]};
            else if (a_reg < m_reg)
            begin
                a_reg <= m_reg;
                m_reg <= a_reg;
            end
            else
                a_reg <= a_reg - m_reg;
        end
    end

    assign stat.done    = done_reg;
    assign stat.coprime = coprime_reg;
    assign stat.neg     = flip_reg;

endmodule

`default_nettype wire

// ----- src/solovay_strassen_primality.sv -----
// ---------------------------------------------------------------------------
// solovay_strassen_primality
// Deterministic Solovay-Strassen test over odd bases 3, 5, 7, ...
// ---------------------------------------------------------------------------
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_stall, candidate            | sink
//  out     | out_valid, out_stall, is_prime, verdict  | source
//  cfg     | cfg_valid, cfg_ready, cfg_data           | sink
//
//  Trivial candidates go straight from idle to the result. Each round takes a
//  check state, the serial remainder and the Jacobi loop, then bit-serial
//  modular exponentiation.
//  Reset: round_count returns to 14; the sequencer state and out_valid clear.
//  One item at a time; out_stall holds the result register and in_stall
//  stays high until the result can be loaded.
`timescale 1ns / 1ps
`default_nettype none

`include "solovay_strassen_primality_defines.svh"

module solovay_strassen_primality #(
    parameter int NUMBER_BITS = ssp_pkg::NUMBER_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [ssp_pkg::CAND_W-1:0]  candidate,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             is_prime,
    output logic [2:0]                       verdict,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [ssp_pkg::ROUND_W-1:0] cfg_data
);
    import ssp_pkg::*;

    localparam int NB = NUMBER_BITS;
    localparam int CW = $clog2(NB + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_JAC   = 7'b0000100,
        S_PBIT  = 7'b0001000,
        S_SQ    = 7'b0010000,
        S_MUL   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [ROUND_W-1:0] round_count_reg, rnd_reg;
    logic [BASE_W-1:0] base_reg;
    logic [NB-1:0]     n_reg, e_reg, acc_reg;
    logic [CW-1:0]     bit_cnt_reg;
    logic              neg_reg;
    verdict_t          verd_reg;
    logic              out_valid_reg, is_prime_reg;
    verdict_t          verdict_reg;

    logic [NB+CAND_W-1:0] cand_wide;
    logic [NB-1:0]        n_in;
    logic [NB+BASE_W-1:0] base_wide;
    logic [NB-1:0]        base_ext;
    logic                 accept, out_free;
    logic                 jac_start, mul_start;
    logic [NB-1:0]        mul_a, mul_b, mul_res;
    logic                 mul_done;
    jac_stat_t            jstat;
    logic                 euler_ok;

    assign cand_wide = {{NB{1'b0}}, candidate};
    assign n_in      = cand_wide[NB-1:0];
    assign base_wide = {{NB{1'b0}}, base_reg};
    assign base_ext  = base_wide[NB-1:0];
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign euler_ok  = (acc_reg == NB'(1) && !neg_reg) ||
                       (acc_reg == n_reg - NB'(1) && neg_reg);

    // Configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            round_count_reg <= ROUND_RESET;
        else if (cfg_valid && cfg_ready)
            round_count_reg <= cfg_data;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        jac_start  = 1'b0;
        mul_start  = 1'b0;
        mul_a      = acc_reg;
        mul_b      = acc_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (n_in[NB-1:1] == '0 || (n_in[NB-1:2] == '0 && n_in[1]) || !n_in[0])
                        state_next = S_DONE;
                    else
                        state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (rnd_reg == round_count_reg || base_ext == n_reg)
                    state_next = S_DONE;
                else
                begin
                    jac_start  = 1'b1;
                    state_next = S_JAC;
                end
            end
            S_JAC:
            begin
                if (jstat.done)
                    state_next = jstat.coprime ? S_PBIT : S_DONE;
            end
            S_PBIT:
            begin
                if (bit_cnt_reg == '0)
                    state_next = euler_ok ? S_CHECK : S_DONE;
                else
                begin
                    mul_start  = 1'b1;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                if (mul_done)
                begin
                    if (e_reg[NB-1])
                    begin
                        mul_start  = 1'b1;
                        mul_a      = mul_res;
                        mul_b      = base_ext;
                        state_next = S_MUL;
                    end
                    else
                        state_next = S_PBIT;
                end
            end
            S_MUL:
            begin
                if (mul_done)
                    state_next = S_PBIT;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Round and exponent datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                n_reg    <= n_in;
                rnd_reg  <= '0;
                base_reg <= BASE_W'(3);
                if (n_in[NB-1:2] == '0 && n_in[1])
                    verd_reg <= V_SMALL;
                else
                    verd_reg <= V_TRIVIAL;
            end
            S_CHECK:
            begin
                if (rnd_reg == round_count_reg)
                    verd_reg <= V_PROBABLE;
                else if (base_ext == n_reg)
                    verd_reg <= V_SMALL;
            end
            S_JAC:
            begin
                neg_reg     <= jstat.neg;
                acc_reg     <= NB'(1);
                e_reg       <= {1'b0, n_reg[NB-1:1]};
                bit_cnt_reg <= CW'(NB);
                verd_reg    <= V_GCD;
            end
            S_PBIT:
            begin
                if (bit_cnt_reg == '0)
                begin
                    verd_reg <= V_EULER;
                    rnd_reg  <= rnd_reg + 1'b1;
                    base_reg <= base_reg + BASE_W'(2);
                end
            end
            S_SQ:
            begin
                if (mul_done)
                begin
                    acc_reg <= mul_res;
                    if (!e_reg[NB-1])
                    begin
                        e_reg       <= {e_reg[NB-2:0], 1'b0};
                        bit_cnt_reg <= bit_cnt_reg - 1'b1;
                    end
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    acc_reg     <= mul_res;
                    e_reg       <= {e_reg[NB-2:0], 1'b0};
                    bit_cnt_reg <= bit_cnt_reg - 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    verdict_reg  <= verd_reg;
                    is_prime_reg <= (verd_reg == V_SMALL) || (verd_reg == V_PROBABLE);
                end
            end
            default:
            begin
                verd_reg <= V_TRIVIAL;
            end
        endcase
    end

    ssp_jacobi #(.NB(NB)) u_jacobi (
        .clk   (clk),
        .rst_n (rst_n),
        .start (jac_start),
        .n     (n_reg),
        .base  (base_reg),
        .stat  (jstat)
    );

    ssp_modmul #(.NB(NB)) u_modmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .m      (n_reg),
        .done   (mul_done),
        .result (mul_res)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;
    assign verdict   = verdict_reg;

    // Checks
    `SSP_ASSERT_IMP(a_prime_match, out_valid,
        is_prime == (verdict == V_SMALL || verdict == V_PROBABLE),
        "is_prime disagrees with verdict")
    `SSP_ASSERT_IMP(a_verdict_range, out_valid, verdict <= V_PROBABLE,
        "verdict code out of range")
    `SSP_ASSERT_NXT(a_busy_after_accept, accept, in_stall,
        "input not stalled after a transfer")
    `SSP_ASSERT_IMP(a_base_below_n, state_reg == S_SQ || state_reg == S_MUL,
        base_ext < n_reg, "base not below candidate during exponentiation")

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the Solovay-Strassen primality tester: directed
// candidates (trivial, small, gcd, Euler-Jacobi, zero and many rounds), then
// random candidates under random idling on both channels and several round
// counts, every result checked in order against a local predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import ssp_pkg::*;

    localparam int WATCHDOG_LIMIT = 600000;
    localparam int DRAIN_CYCLES   = 50;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [CAND_W-1:0]   candidate;
    logic                out_valid;
    logic                out_stall;
    logic                is_prime;
    logic [2:0]          verdict;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [ROUND_W-1:0]  cfg_data;

    typedef struct {
        logic     prime;
        verdict_t code;
    } verdict_rec_t;

    verdict_rec_t       pending_verdicts[$];
    logic [ROUND_W-1:0] rounds_cfg;
    int                 errors;
    int                 items_sent;
    int                 results_seen;
    int                 idle_cycles;
    bit                 quiet;

    solovay_strassen_primality dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .candidate (candidate),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .is_prime  (is_prime),
        .verdict   (verdict),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // ---------------- predictor ----------------
    function automatic longint unsigned pow_mod_n(longint unsigned b, longint unsigned e,
                                                  longint unsigned m);
        longint unsigned acc;
        acc = 1 % m;
        b = b % m;
        while (e != 0)
        begin
            if (e[0])
                acc = (acc * b) % m;
            b = (b * b) % m;
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
        longint unsigned t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // Jacobi symbol (a/n), n odd >= 3
    function automatic int jacobi_of(longint unsigned a, longint unsigned n);
        int              sgn;
        longint unsigned t;
        sgn = 1;
        a = a % n;
        while (a != 0)
        begin
            while (a[0] == 1'b0)
            begin
                a = a >> 1;
                if (n[2:0] == 3'd3 || n[2:0] == 3'd5)
                    sgn = -sgn;
            end
            t = a;
            a = n;
            n = t;
            if (a[1:0] == 2'd3 && n[1:0] == 2'd3)
                sgn = -sgn;
            a = a % n;
        end
        return (n == 1) ? sgn : 0;
    endfunction

    function automatic verdict_rec_t predict_verdict(logic [CAND_W-1:0] cand,
                                                     logic [ROUND_W-1:0] rounds);
        longint unsigned n;
        longint unsigned base;
        longint unsigned pw;
        int              js;
        verdict_rec_t    rec;
        n = cand;
        base = 3;
        rec.code = V_PROBABLE;
        if (n < 2)
            rec.code = V_TRIVIAL;
        else if (n == 2 || n == 3)
            rec.code = V_SMALL;
        else if (n[0] == 1'b0)
            rec.code = V_TRIVIAL;
        else
        begin
            for (int r = 0; r < rounds; r++)
            begin
                if (base == n)
                begin
                    rec.code = V_SMALL;
                    break;
                end
                if (gcd_of(n, base) > 1)
                begin
                    rec.code = V_GCD;
                    break;
                end
                pw = pow_mod_n(base, (n - 1) >> 1, n);
                js = jacobi_of(base, n);
                if (!((pw == 1 && js == 1) || (pw == n - 1 && js == -1)))
                begin
                    rec.code = V_EULER;
                    break;
                end
                base += 2;
            end
        end
        rec.prime = (rec.code == V_SMALL || rec.code == V_PROBABLE);
        return rec;
    endfunction

    // ---------------- result checker and watchdog ----------------
    always @(posedge clk)
    begin
        verdict_rec_t want;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t timeout: no transfer for %0d cycles", $time, idle_cycles);
                $display("== FAIL ==");
                $finish;
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (pending_verdicts.size() == 0)
                begin
                    $display("%0t unexpected result: is_prime=%0b verdict=%0d",
                             $time, is_prime, verdict);
                    errors++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (is_prime !== want.prime)
                    begin
                        $display("%0t is_prime mismatch: expected %0b actual %0b",
                                 $time, want.prime, is_prime);
                        errors++;
                    end
                    if (verdict !== want.code)
                    begin
                        $display("%0t verdict mismatch: expected %0d actual %0d",
                                 $time, want.code, verdict);
                        errors++;
                    end
                end
            end
        end
    end

    // receiver stall bursts
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // ---------------- shared tasks ----------------
    task automatic send_candidate(input logic [CAND_W-1:0] cand);
        if (!quiet && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 10)) @(negedge clk);
        in_valid  = 1'b1;
        candidate = cand;
        do
            @(posedge clk);
        while (in_stall);
        pending_verdicts.push_back(predict_verdict(cand, rounds_cfg));
        items_sent++;
        @(negedge clk);
        in_valid  = 1'b0;
        candidate = $urandom;
    endtask

    task automatic wait_drained();
        while (pending_verdicts.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_rounds(input logic [ROUND_W-1:0] value);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        rounds_cfg = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // random candidate: mostly odd, mix of small and full range
    function automatic logic [CAND_W-1:0] pick_candidate();
        logic [CAND_W-1:0] c;
        case ($urandom_range(0, 9))
            0:       c = $urandom_range(0, 40);
            1:       c = $urandom;
            2, 3:    c = $urandom_range(5, 2000) | 1;
            default: c = $urandom | 1;
        endcase
        return c;
    endfunction

    // ---------------- tests ----------------
    task automatic test_trivial();
        send_candidate(32'd0);
        send_candidate(32'd1);
        send_candidate(32'd2);
        send_candidate(32'd3);
        send_candidate(32'd4);
        send_candidate(32'hFFFF_FFFE);
        send_candidate(32'hFFFF_FFFF);
    endtask

    task automatic test_default_rounds();
        send_candidate(32'd5);
        send_candidate(32'd9);
        send_candidate(32'd25);
        send_candidate(32'd561);
        send_candidate(32'd1105);
        send_candidate(32'd4294967291);
        send_candidate(32'h8000_0001);
    endtask

    task automatic test_zero_rounds();
        write_rounds(6'd0);
        send_candidate(32'd7);
        send_candidate(32'd9);
        send_candidate(32'd3);
        send_candidate(32'd6);
        send_candidate(32'hFFFF_FFFF);
    endtask

    task automatic test_many_rounds();
        write_rounds(6'd63);
        send_candidate(32'd101);
        send_candidate(32'd127);
        send_candidate(32'd7919);
        send_candidate(32'd65537);
    endtask

    task automatic test_drain_pause();
        write_rounds(6'd1);
        send_candidate(32'd15);
        send_candidate(32'd341);
        wait_drained();
        send_candidate(32'd13);
    endtask

    task automatic test_random(input int count, input logic [ROUND_W-1:0] rounds);
        write_rounds(rounds);
        repeat (count) send_candidate(pick_candidate());
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        candidate  = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        rounds_cfg = ROUND_RESET;
        errors       = 0;
        items_sent   = 0;
        results_seen = 0;
        idle_cycles  = 0;
        quiet        = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_trivial();
        test_default_rounds();
        test_zero_rounds();
        test_many_rounds();
        test_drain_pause();
        test_random(30, 6'd3);
        test_random(20, 6'd2);
        test_random(10, 6'd14);
        quiet = 1'b1;
        test_random(15, 6'd4);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pending_verdicts.size() != 0)
        begin
            $display("%0t %0d results never arrived", $time, pending_verdicts.size());
            errors++;
        end
        $display("Checked %0d results for %0d candidates over round counts 0 to 63,",
                 results_seen, items_sent);
        $display("with trivial, gcd, Euler-Jacobi, base-hit and probable verdicts.");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/ssp_pkg.sv
src/ssp_modmul.sv
src/ssp_jacobi.sv
src/solovay_strassen_primality.sv
test/tb.sv
